// ----- sv/evr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_pkg
// Shared constants, register codes and the CORDIC arctangent table of the
// z-x-z Euler vector rotator.
// ----------------------------------------------------------------------------
package evr_pkg;

    localparam int DEF_COMPONENT_WIDTH = 18;
    localparam int DEF_ANGLE_WIDTH     = 16;
    localparam int GUARD_BITS          = 8;
    localparam int CORDIC_STEPS        = 30;
    localparam int STEP_W              = $clog2(CORDIC_STEPS);
    localparam int PIPE_DEPTH          = 7;
    localparam int PADDR_W             = 4;

    localparam logic signed [31:0] GAIN_Q30     = 32'sd652032874;
    localparam logic [31:0]        EIGHTH_TURN  = 32'h2000_0000;

    typedef enum logic [1:0] {
        REG_FIRST  = 2'd0,
        REG_SECOND = 2'd1,
        REG_THIRD  = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    function automatic logic signed [31:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/evr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_if
// Valid/ready channels carrying the input vector and the rotated vector.
// ----------------------------------------------------------------------------
interface evr_vec_if #(
    parameter int COMPONENT_WIDTH = evr_pkg::DEF_COMPONENT_WIDTH
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] vec_x;
    logic signed [COMPONENT_WIDTH-1:0] vec_y;
    logic signed [COMPONENT_WIDTH-1:0] vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface evr_rot_if #(
    parameter int COMPONENT_WIDTH = evr_pkg::DEF_COMPONENT_WIDTH
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] rot_x;
    logic signed [COMPONENT_WIDTH-1:0] rot_y;
    logic signed [COMPONENT_WIDTH-1:0] rot_z;

    modport source (output valid, rot_x, rot_y, rot_z, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// ----- sv/euler_zxz_vector_rotator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zxz_vector_rotator
// Rotates a signed fixed-point 3-D vector about z, then x, then z by three
// programmable angles; results are rounded and saturated.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  i_vec     in         valid/ready           vec_x, vec_y, vec_z
//  o_rot     out        valid/ready           rot_x, rot_y, rot_z
//  apb       in         psel/penable/pwrite   paddr, pwdata (prdata back)
//
//  One item per cycle while o_rot.ready is high and the CORDIC unit is idle.
//  Each stage holds its item and its own valid bit; a stalled stage fills
//  bubbles ahead of it, so nothing is lost or repeated.
//  After reset and after every register write a shared CORDIC unit derives
//  cos/sin for all three angles in turn, during which i_vec.ready is low.
// ----------------------------------------------------------------------------
module euler_zxz_vector_rotator #(
    parameter int COMPONENT_WIDTH = evr_pkg::DEF_COMPONENT_WIDTH,
    parameter int ANGLE_WIDTH     = evr_pkg::DEF_ANGLE_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    evr_vec_if.sink                     i_vec,
    evr_rot_if.source                   o_rot,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [evr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import evr_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int DW = CW + GUARD_BITS + 2;
    localparam int PW = DW + 32;
    localparam int RW = DW + 1 - GUARD_BITS;
    localparam logic [PW-1:0]        HALF_Q30 = {{(PW-30){1'b0}}, 1'b1, 29'b0};
    localparam logic signed [DW:0]   HALF_LSB = {{(DW-GUARD_BITS+1){1'b0}}, 1'b1,
                                                 {(GUARD_BITS-1){1'b0}}};
    localparam logic signed [RW-1:0] SAT_HI = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef logic signed [DW-1:0] t_comp;
    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        t_prod pa;
        t_prod pb;
        t_prod pc;
        t_prod pd;
        t_comp pass;
    } t_mul;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
    } t_vec;

    typedef enum logic [1:0] {
        C_IDLE,
        C_LOAD,
        C_ITER,
        C_STORE
    } t_cstate;

    function automatic t_comp rnd(input t_prod p);
        logic [PW-1:0] m;
        logic [PW-1:0] q;
        m = p[PW-1] ? -p : p;
        q = (m + HALF_Q30) >> 30;
        return p[PW-1] ? -q[DW-1:0] : q[DW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [ANGLE_WIDTH-1:0] r_ang [3];
    logic                   cfg_wr;
    t_reg_idx               wr_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang[0] <= '0;
            r_ang[1] <= '0;
            r_ang[2] <= '0;
        end else if (cfg_wr) begin
            case (wr_idx)
                REG_FIRST:  r_ang[0] <= pwdata[ANGLE_WIDTH-1:0];
                REG_SECOND: r_ang[1] <= pwdata[ANGLE_WIDTH-1:0];
                REG_THIRD:  r_ang[2] <= pwdata[ANGLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            REG_FIRST:  prdata = 32'(r_ang[0]);
            REG_SECOND: prdata = 32'(r_ang[1]);
            REG_THIRD:  prdata = 32'(r_ang[2]);
            default:    prdata = '0;
        endcase
    end

    // ---------------- CORDIC cos/sin unit ----------------
    t_cstate            r_cst;
    logic               r_busy;
    t_reg_idx           r_sel;
    logic [STEP_W-1:0]  r_step;
    logic [1:0]         r_quad;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic signed [31:0] r_cos [3];
    logic signed [31:0] r_sin [3];
    logic [31:0]        phase;
    logic signed [31:0] dx, dy, at;

    assign phase = {r_ang[r_sel[1:0]], {(32-ANGLE_WIDTH){1'b0}}} + EIGHTH_TURN;
    assign dx    = r_cy >>> r_step;
    assign dy    = r_cx >>> r_step;
    assign at    = atan_turn(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst  <= C_LOAD;
            r_busy <= 1'b1;
            r_sel  <= REG_FIRST;
            r_step <= '0;
        end else if (cfg_wr) begin
            r_cst  <= C_LOAD;
            r_busy <= 1'b1;
            r_sel  <= REG_FIRST;
        end else begin
            case (r_cst)
                C_LOAD: begin
                    r_cx   <= GAIN_Q30;
                    r_cy   <= '0;
                    r_cz   <= $signed({2'b00, phase[29:0]}) - $signed(EIGHTH_TURN);
                    r_quad <= phase[31:30];
                    r_step <= '0;
                    r_cst  <= C_ITER;
                end
                C_ITER: begin
                    if (!r_cz[31]) begin
                        r_cx <= r_cx - dx;
                        r_cy <= r_cy + dy;
                        r_cz <= r_cz - at;
                    end else begin
                        r_cx <= r_cx + dx;
                        r_cy <= r_cy - dy;
                        r_cz <= r_cz + at;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_cst <= C_STORE;
                    end
                end
                C_STORE: begin
                    case (r_quad)
                        2'd0: begin
                            r_cos[r_sel[1:0]] <= r_cx;
                            r_sin[r_sel[1:0]] <= r_cy;
                        end
                        2'd1: begin
                            r_cos[r_sel[1:0]] <= -r_cy;
                            r_sin[r_sel[1:0]] <= r_cx;
                        end
                        2'd2: begin
                            r_cos[r_sel[1:0]] <= -r_cx;
                            r_sin[r_sel[1:0]] <= -r_cy;
                        end
                        default: begin
                            r_cos[r_sel[1:0]] <= r_cy;
                            r_sin[r_sel[1:0]] <= -r_cx;
                        end
                    endcase
                    if (r_sel == REG_THIRD) begin
                        r_cst  <= C_IDLE;
                        r_busy <= 1'b0;
                    end else begin
                        r_sel <= t_reg_idx'(r_sel + 2'd1);
                        r_cst <= C_LOAD;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- vector pipeline ----------------
    logic [PIPE_DEPTH:1] r_v;
    logic [PIPE_DEPTH:1] en;
    t_mul  r_m1, r_m3, r_m5;
    t_vec  r_s2, r_s4, r_s6;
    logic signed [CW-1:0] r_ox, r_oy, r_oz;
    t_comp ix, iy, iz;
    logic  in_acc;

    always_comb begin
        en[PIPE_DEPTH] = !r_v[PIPE_DEPTH] || o_rot.ready;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_vec.ready = en[1] && !r_busy;
    assign in_acc      = i_vec.valid && i_vec.ready;

    assign ix = {{2{i_vec.vec_x[CW-1]}}, i_vec.vec_x, {GUARD_BITS{1'b0}}};
    assign iy = {{2{i_vec.vec_y[CW-1]}}, i_vec.vec_y, {GUARD_BITS{1'b0}}};
    assign iz = {{2{i_vec.vec_z[CW-1]}}, i_vec.vec_z, {GUARD_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= in_acc;
            end
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    function automatic t_comp sat_out(input t_comp v);
        logic signed [DW:0]   t;
        logic signed [RW-1:0] r;
        t = DW'(v) + HALF_LSB;
        t = {v[DW-1], v} + HALF_LSB;
        r = RW'(t >>> GUARD_BITS);
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return DW'(r);
    endfunction

    t_comp sx, sy, sz;
    assign sx = sat_out(r_s6.x);
    assign sy = sat_out(r_s6.y);
    assign sz = sat_out(r_s6.z);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_m1.pa   <= ix * r_cos[0];
            r_m1.pb   <= iy * r_sin[0];
            r_m1.pc   <= ix * r_sin[0];
            r_m1.pd   <= iy * r_cos[0];
            r_m1.pass <= iz;
        end
        if (en[2]) begin
            r_s2.x <= rnd(r_m1.pa) - rnd(r_m1.pb);
            r_s2.y <= rnd(r_m1.pc) + rnd(r_m1.pd);
            r_s2.z <= r_m1.pass;
        end
        if (en[3]) begin
            r_m3.pa   <= r_s2.y * r_cos[1];
            r_m3.pb   <= r_s2.z * r_sin[1];
            r_m3.pc   <= r_s2.y * r_sin[1];
            r_m3.pd   <= r_s2.z * r_cos[1];
            r_m3.pass <= r_s2.x;
        end
        if (en[4]) begin
            r_s4.x <= r_m3.pass;
            r_s4.y <= rnd(r_m3.pa) - rnd(r_m3.pb);
            r_s4.z <= rnd(r_m3.pc) + rnd(r_m3.pd);
        end
        if (en[5]) begin
            r_m5.pa   <= r_s4.x * r_cos[2];
            r_m5.pb   <= r_s4.y * r_sin[2];
            r_m5.pc   <= r_s4.x * r_sin[2];
            r_m5.pd   <= r_s4.y * r_cos[2];
            r_m5.pass <= r_s4.z;
        end
        if (en[6]) begin
            r_s6.x <= rnd(r_m5.pa) - rnd(r_m5.pb);
            r_s6.y <= rnd(r_m5.pc) + rnd(r_m5.pd);
            r_s6.z <= r_m5.pass;
        end
        if (en[7]) begin
            r_ox <= sx[CW-1:0];
            r_oy <= sy[CW-1:0];
            r_oz <= sz[CW-1:0];
        end
    end

    assign o_rot.valid = r_v[PIPE_DEPTH];
    assign o_rot.rot_x = r_ox;
    assign o_rot.rot_y = r_oy;
    assign o_rot.rot_z = r_oz;

endmodule

// ----- sv/evr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_checker
// Port-level checks of the Euler vector rotator: item accounting, output
// hold under stall, and input blocking after a register write.
// ----------------------------------------------------------------------------
module evr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_cfg_wr
);
    import evr_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (!in_acc && out_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result without an item in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more items in flight than stages");

    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> !i_in_ready)
        else $error("input taken while angles are recomputed");

endmodule

bind euler_zxz_vector_rotator evr_checker u_evr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vec.valid),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_rot.valid),
    .i_out_ready (o_rot.ready),
    .i_cfg_wr    (psel && penable && pwrite)
);
